// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OGR_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define OGR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ogr_pkg.sv =====
package ogr_pkg;

  localparam int GLYPH_W     = 6;
  localparam int GLYPH_COUNT = 97;

  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] LAST_CODE    = 8'd128;
  localparam logic [7:0] CTRL_CMD     = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;
  localparam logic [7:0] PAGE_CMD     = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD  = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD = 8'h10;
  localparam logic [7:0] ADDR_RESET   = 8'h78;

  // byte positions within one frame pair
  localparam logic [4:0] POS_CUR_ADDR  = 5'd0;
  localparam logic [4:0] POS_CUR_CTRL  = 5'd1;
  localparam logic [4:0] POS_PAGE      = 5'd2;
  localparam logic [4:0] POS_COL_LO    = 5'd3;
  localparam logic [4:0] POS_COL_HI    = 5'd4;
  localparam logic [4:0] POS_DAT_ADDR  = 5'd5;
  localparam logic [4:0] POS_DAT_CTRL  = 5'd6;
  localparam logic [4:0] POS_GLYPH     = 5'd7;
  localparam logic [4:0] POS_END_NORM  = 5'd12;
  localparam logic [4:0] POS_END_DBL   = 5'd18;

  typedef enum logic [2:0] {
    SEL_ADDR,
    SEL_CTRL_CMD,
    SEL_PAGE,
    SEL_COL_LO,
    SEL_COL_HI,
    SEL_CTRL_DATA,
    SEL_GLYPH
  } byte_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    byte_sel_t sel;
    logic      half;
    logic [2:0] col;
    logic      fs;
    logic      fe;
    logic      last;
  } ogr_cmd_t;

  typedef struct packed {
    logic dbl;
  } ogr_stat_t;

  // row = {col0, col1, ... col5}
  localparam logic [47:0] FONT_ROM [GLYPH_COUNT] = '{
    48'h000000000000, 48'h0000065F0600, 48'h000703000703, 48'h00247E247E24,
    48'h00242B6A1200, 48'h006313086463, 48'h003649562050, 48'h000007030000,
    48'h00003E410000, 48'h0000413E0000, 48'h00083E1C3E08, 48'h0008083E0808,
    48'h0000E0600000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003E5149453E, 48'h0000427F4000, 48'h006251494946, 48'h002249494936,
    48'h001814127F10, 48'h002F49494931, 48'h003C4A494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291E, 48'h00006C6C0000, 48'h0000EC6C0000,
    48'h000814224100, 48'h002424242424, 48'h000041221408, 48'h000201590906,
    48'h003E415D551E, 48'h007E1111117E, 48'h007F49494936, 48'h003E41414122,
    48'h007F4141413E, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
    48'h007F0808087F, 48'h0000417F4100, 48'h00304040403F, 48'h007F08142241,
    48'h007F40404040, 48'h007F0204027F, 48'h007F0204087F, 48'h003E4141413E,
    48'h007F09090906, 48'h003E4151215E, 48'h007F09091966, 48'h002649494932,
    48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F403C403F,
    48'h006314081463, 48'h000708700807, 48'h007149454300, 48'h00007F414100,
    48'h000204081020, 48'h000041417F00, 48'h000402010204, 48'h808080808080,
    48'h000003070000, 48'h002054545478, 48'h007F44444438, 48'h003844444428,
    48'h00384444447F, 48'h003854545408, 48'h00087E090900, 48'h0018A4A4A47C,
    48'h007F04047800, 48'h0000007D4000, 48'h004080847D00, 48'h007F10284400,
    48'h0000007F4000, 48'h007C04180478, 48'h007C04047800, 48'h003844444438,
    48'h00FC44444438, 48'h0038444444FC, 48'h004478440408, 48'h000854545420,
    48'h00043E442400, 48'h003C40207C00, 48'h001C2040201C, 48'h003C6030603C,
    48'h006C10106C00, 48'h009CA0603C00, 48'h006454544C00, 48'h00083E414100,
    48'h000000770000, 48'h000041413E08, 48'h000201020100, 48'h003C2623263C,
    48'h001EA1E12112
  };

  function automatic logic [7:0] font_col(input logic [7:0] code, input logic [2:0] c);
    logic [7:0]  off;
    logic [47:0] row;
    logic [5:0]  sh;
    off = code - FIRST_CODE;
    row = '0;
    if (code >= FIRST_CODE && code <= LAST_CODE) begin
      row = FONT_ROM[off[6:0]];
    end
    sh = 6'(8 * (GLYPH_W - 1 - int'(c)));
    return row[sh +: 8];
  endfunction

  function automatic logic [15:0] stretch(input logic [7:0] v);
    logic [15:0] r;
    for (int t = 0; t < 8; t++) begin
      r[2*t]   = v[t];
      r[2*t+1] = v[t];
    end
    return r;
  endfunction

endpackage

// ===== src/oled_glyph_renderer.sv =====
// Draws one character per transaction as a stream of I2C write-frame bytes:
// a cursor frame and a data frame for a 6x8 glyph (13 bytes), or two such
// pairs for a 12x16 glyph (38 bytes). A byte sequencer emits one byte per
// clock; out_valid follows through the output register, and start is taken
// again in the cycle after the final byte is issued. Each byte is on the
// out_ ports for exactly one cycle and cannot be stalled, so the receiver
// must take a byte every cycle, typically into a FIFO ahead of the bus
// serialiser. Codes outside 32..128 draw a blank glyph. Write device_address
// only while busy is low and the last byte has left.
module oled_glyph_renderer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_column,
  input  logic [2:0] in_page,
  input  logic [7:0] in_char_code,
  input  logic       in_invert,
  input  logic       in_double_size,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_frame_start,
  output logic       out_frame_end,
  output logic       out_last,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import ogr_pkg::*;

  ogr_cmd_t   cmd;
  ogr_stat_t  stat;
  logic [7:0] dev_addr_r;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'b00) ? {24'b0, dev_addr_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= ADDR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      dev_addr_r <= pwdata[7:0];
    end
  end

  ogr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ogr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .dev_addr        (dev_addr_r),
    .in_column       (in_column),
    .in_page         (in_page),
    .in_char_code    (in_char_code),
    .in_invert       (in_invert),
    .in_double_size  (in_double_size),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last)
  );

endmodule

// ===== src/ogr_ctrl.sv =====
`include "assert_macros.svh"

module ogr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ogr_pkg::ogr_stat_t stat,
  output ogr_pkg::ogr_cmd_t  cmd
);
  import ogr_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t     state_r, state_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic       half_r, half_nxt;
  logic       busy_r, busy_nxt;
  logic [4:0] off;
  logic       at_end;

  assign busy = busy_r;
  assign off  = pos_r - POS_GLYPH;
  assign at_end = (pos_r == (stat.dbl ? POS_END_DBL : POS_END_NORM));

  always_comb begin
    cmd      = '0;
    cmd.load = start && !busy_r;
    cmd.emit = (state_r == ST_RUN);
    cmd.half = half_r;
    cmd.col  = stat.dbl ? off[3:1] : off[2:0];
    case (pos_r)
      POS_CUR_ADDR: begin
        cmd.sel = SEL_ADDR;
        cmd.fs  = 1'b1;
      end
      POS_CUR_CTRL: cmd.sel = SEL_CTRL_CMD;
      POS_PAGE:     cmd.sel = SEL_PAGE;
      POS_COL_LO:   cmd.sel = SEL_COL_LO;
      POS_COL_HI: begin
        cmd.sel = SEL_COL_HI;
        cmd.fe  = 1'b1;
      end
      POS_DAT_ADDR: begin
        cmd.sel = SEL_ADDR;
        cmd.fs  = 1'b1;
      end
      POS_DAT_CTRL: cmd.sel = SEL_CTRL_DATA;
      default: begin
        cmd.sel  = SEL_GLYPH;
        cmd.fe   = at_end;
        cmd.last = at_end && (half_r || !stat.dbl);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    half_nxt  = half_r;
    busy_nxt  = busy_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_RUN;
          pos_nxt   = POS_CUR_ADDR;
          half_nxt  = 1'b0;
          busy_nxt  = 1'b1;
        end
      end
      ST_RUN: begin
        if (cmd.last) begin
          state_nxt = ST_IDLE;
          busy_nxt  = 1'b0;
        end else if (at_end) begin
          pos_nxt  = POS_CUR_ADDR;
          half_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + 5'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      half_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      half_r  <= half_nxt;
      busy_r  <= busy_nxt;
    end
  end

  `OGR_ASSERT_NEXT(a_load_begins, clk, rst_n, cmd.load, cmd.emit && pos_r == POS_CUR_ADDR && !half_r)
  `OGR_ASSERT_NEXT(a_last_frees, clk, rst_n, cmd.emit && cmd.last, !busy_r && !cmd.emit)
  `OGR_ASSERT_NEXT(a_end_then_start, clk, rst_n, cmd.emit && cmd.fe && !cmd.last, cmd.emit && cmd.fs)
  `OGR_ASSERT_IMPL(a_pos_bound, clk, rst_n, state_r == ST_RUN, pos_r <= POS_END_DBL && busy_r)

endmodule

// ===== src/ogr_dp.sv =====
module ogr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ogr_pkg::ogr_cmd_t  cmd,
  output ogr_pkg::ogr_stat_t stat,
  input  logic [7:0]        dev_addr,
  input  logic [7:0]        in_column,
  input  logic [2:0]        in_page,
  input  logic [7:0]        in_char_code,
  input  logic              in_invert,
  input  logic              in_double_size,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_frame_start,
  output logic              out_frame_end,
  output logic              out_last
);
  import ogr_pkg::*;

  logic [7:0]  column_r;
  logic [2:0]  page_r;
  logic [7:0]  code_r;
  logic        inv_r;
  logic        dbl_r;
  logic        valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        fs_r, fe_r, last_r;
  logic [7:0]  gcol;
  logic [15:0] wide;
  logic [2:0]  pg;

  assign stat.dbl = dbl_r;

  always_comb begin
    gcol = font_col(code_r, cmd.col) ^ {8{inv_r}};
    wide = stretch(gcol);
    pg   = page_r + {2'b00, cmd.half};
    case (cmd.sel)
      SEL_ADDR:      byte_nxt = dev_addr;
      SEL_CTRL_CMD:  byte_nxt = CTRL_CMD;
      SEL_PAGE:      byte_nxt = PAGE_CMD | {5'b0, pg};
      SEL_COL_LO:    byte_nxt = COL_LOW_CMD | {4'b0, column_r[3:0]};
      SEL_COL_HI:    byte_nxt = COL_HIGH_CMD | {4'b0, column_r[7:4]};
      SEL_CTRL_DATA: byte_nxt = CTRL_DATA;
      SEL_GLYPH:     byte_nxt = !dbl_r ? gcol : (cmd.half ? wide[15:8] : wide[7:0]);
      default:       byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dbl_r   <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      if (cmd.load) begin
        dbl_r <= in_double_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      column_r <= in_column;
      page_r   <= in_page;
      code_r   <= in_char_code;
      inv_r    <= in_invert;
    end
    byte_r <= byte_nxt;
    fs_r   <= cmd.fs;
    fe_r   <= cmd.fe;
    last_r <= cmd.last;
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_frame_start = fs_r;
  assign out_frame_end   = fe_r;
  assign out_last        = last_r;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT        = 200000;
  localparam int         RANDOM_PER_PHASE   = 32;
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [7:0] RESET_ADDR         = 8'h78;
  localparam logic [7:0] CMD_CTRL           = 8'h00;
  localparam logic [7:0] DATA_CTRL          = 8'h40;
  localparam logic [7:0] PAGE_BASE          = 8'hB0;
  localparam logic [7:0] COL_LO_BASE        = 8'h00;
  localparam logic [7:0] COL_HI_BASE        = 8'h10;
  localparam int         CODE_LO            = 32;
  localparam int         CODE_HI            = 128;

  // one row per printable code, leftmost column in the top byte
  localparam logic [47:0] GLYPHS [97] = '{
    48'h000000000000, 48'h0000065F0600, 48'h000703000703, 48'h00247E247E24,
    48'h00242B6A1200, 48'h006313086463, 48'h003649562050, 48'h000007030000,
    48'h00003E410000, 48'h0000413E0000, 48'h00083E1C3E08, 48'h0008083E0808,
    48'h0000E0600000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003E5149453E, 48'h0000427F4000, 48'h006251494946, 48'h002249494936,
    48'h001814127F10, 48'h002F49494931, 48'h003C4A494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291E, 48'h00006C6C0000, 48'h0000EC6C0000,
    48'h000814224100, 48'h002424242424, 48'h000041221408, 48'h000201590906,
    48'h003E415D551E, 48'h007E1111117E, 48'h007F49494936, 48'h003E41414122,
    48'h007F4141413E, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
    48'h007F0808087F, 48'h0000417F4100, 48'h00304040403F, 48'h007F08142241,
    48'h007F40404040, 48'h007F0204027F, 48'h007F0204087F, 48'h003E4141413E,
    48'h007F09090906, 48'h003E4151215E, 48'h007F09091966, 48'h002649494932,
    48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F403C403F,
    48'h006314081463, 48'h000708700807, 48'h007149454300, 48'h00007F414100,
    48'h000204081020, 48'h000041417F00, 48'h000402010204, 48'h808080808080,
    48'h000003070000, 48'h002054545478, 48'h007F44444438, 48'h003844444428,
    48'h00384444447F, 48'h003854545408, 48'h00087E090900, 48'h0018A4A4A47C,
    48'h007F04047800, 48'h0000007D4000, 48'h004080847D00, 48'h007F10284400,
    48'h0000007F4000, 48'h007C04180478, 48'h007C04047800, 48'h003844444438,
    48'h00FC44444438, 48'h0038444444FC, 48'h004478440408, 48'h000854545420,
    48'h00043E442400, 48'h003C40207C00, 48'h001C2040201C, 48'h003C6030603C,
    48'h006C10106C00, 48'h009CA0603C00, 48'h006454544C00, 48'h00083E414100,
    48'h000000770000, 48'h000041413E08, 48'h000201020100, 48'h003C2623263C,
    48'h001EA1E12112
  };

  typedef struct packed {
    logic [7:0] data;
    logic       fs;
    logic       fe;
    logic       lst;
  } stream_byte_t;

  class glyph_scoreboard;
    stream_byte_t pending_bytes[$];
    logic [7:0]   dev_addr;
    int           errors;

    function new();
      dev_addr = RESET_ADDR;
      errors   = 0;
    endfunction

    function void push(input logic [7:0] b, input logic fs, input logic fe);
      stream_byte_t e;
      e.data = b;
      e.fs   = fs;
      e.fe   = fe;
      e.lst  = 1'b0;
      pending_bytes.push_back(e);
    endfunction

    function void push_cursor(input logic [7:0] col, input logic [2:0] pg);
      push(dev_addr, 1'b1, 1'b0);
      push(CMD_CTRL, 1'b0, 1'b0);
      push(PAGE_BASE | {5'b0, pg}, 1'b0, 1'b0);
      push(COL_LO_BASE | {4'b0, col[3:0]}, 1'b0, 1'b0);
      push(COL_HI_BASE | {4'b0, col[7:4]}, 1'b0, 1'b1);
    endfunction

    // each pixel row becomes two
    function logic [15:0] widen(input logic [7:0] v);
      logic [15:0] r;
      r = '0;
      for (int t = 0; t < 8; t++) begin
        if (v[t]) r = r | (16'h3 << (2 * t));
      end
      return r;
    endfunction

    function void note_char(input logic [7:0] col, input logic [2:0] pg,
                            input logic [7:0] code, input logic inv, input logic dbl);
      logic [7:0]   cols [6];
      logic [47:0]  row;
      logic [15:0]  w;
      logic [7:0]   b;
      stream_byte_t tail;
      row = '0;
      if (int'(code) >= CODE_LO && int'(code) <= CODE_HI) row = GLYPHS[int'(code) - CODE_LO];
      for (int c = 0; c < 6; c++) cols[c] = row[8 * (5 - c) +: 8] ^ {8{inv}};
      if (!dbl) begin
        push_cursor(col, pg);
        push(dev_addr, 1'b1, 1'b0);
        push(DATA_CTRL, 1'b0, 1'b0);
        for (int c = 0; c < 6; c++) push(cols[c], 1'b0, c == 5);
      end else begin
        for (int h = 0; h < 2; h++) begin
          push_cursor(col, pg + 3'(h));
          push(dev_addr, 1'b1, 1'b0);
          push(DATA_CTRL, 1'b0, 1'b0);
          for (int c = 0; c < 6; c++) begin
            w = widen(cols[c]);
            b = (h == 1) ? w[15:8] : w[7:0];
            push(b, 1'b0, 1'b0);
            push(b, 1'b0, c == 5);
          end
        end
      end
      tail = pending_bytes.pop_back();
      tail.lst = 1'b1;
      pending_bytes.push_back(tail);
    endfunction

    function void check_byte(input logic [7:0] b, input logic fs, input logic fe,
                             input logic lst);
      stream_byte_t e;
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte %02h with nothing pending", b);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      if (b !== e.data) begin
        $error("out_byte: expected %02h, got %02h", e.data, b);
        errors++;
      end
      if (fs !== e.fs) begin
        $error("out_frame_start: expected %0b, got %0b", e.fs, fs);
        errors++;
      end
      if (fe !== e.fe) begin
        $error("out_frame_end: expected %0b, got %0b", e.fe, fe);
        errors++;
      end
      if (lst !== e.lst) begin
        $error("out_last: expected %0b, got %0b", e.lst, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_column;
  logic [2:0]  in_page;
  logic [7:0]  in_char_code;
  logic        in_invert;
  logic        in_double_size;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_frame_start;
  logic        out_frame_end;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  glyph_scoreboard sb = new();
  bit              idle_on;
  int              cycle_count;

  oled_glyph_renderer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_column       (in_column),
    .in_page         (in_page),
    .in_char_code    (in_char_code),
    .in_invert       (in_invert),
    .in_double_size  (in_double_size),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_frame_start (out_frame_start),
    .out_frame_end   (out_frame_end),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_byte(out_byte, out_frame_start, out_frame_end, out_last);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // start stays high after acceptance; the next call either reuses it or drops it for a gap
  // that begins once the block is free again
  task automatic send_char(input logic [7:0] col, input logic [2:0] pg, input logic [7:0] code,
                           input logic inv, input logic dbl);
    if (idle_on && $urandom_range(99) < 13) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat ($urandom_range(0, 40)) @(posedge clk);
    end
    start          <= 1'b1;
    in_column      <= col;
    in_page        <= pg;
    in_char_code   <= code;
    in_invert      <= inv;
    in_double_size <= dbl;
    do @(posedge clk); while (busy);
    sb.note_char(col, pg, code, inv, dbl);
  endtask

  task automatic send_random();
    logic [7:0] code;
    if ($urandom_range(3) == 0) code = 8'($urandom_range(255));
    else code = 8'($urandom_range(CODE_HI, CODE_LO));
    send_char(8'($urandom_range(255)), 3'($urandom_range(7)), code,
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] a, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= {24'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (a == REG_DEVICE_ADDRESS) sb.dev_addr = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [1:0] a, input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== want) begin
      $error("prdata: expected %02h, got %02h", want, prdata[7:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] addr_set [4];
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_column      <= '0;
    in_page        <= '0;
    in_char_code   <= '0;
    in_invert      <= 1'b0;
    in_double_size <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    idle_on        = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_read(REG_DEVICE_ADDRESS, RESET_ADDR);

    // directed: font edges, blank codes, column/page extremes, page wrap
    send_char(8'h00, 3'd0, 8'd65,  1'b0, 1'b0);
    send_char(8'hFF, 3'd7, 8'd65,  1'b1, 1'b0);
    send_char(8'h0F, 3'd3, 8'd32,  1'b0, 1'b0);
    send_char(8'hF0, 3'd4, 8'd128, 1'b0, 1'b0);
    send_char(8'h5A, 3'd1, 8'd128, 1'b1, 1'b1);
    send_char(8'hA5, 3'd2, 8'd31,  1'b0, 1'b0);
    send_char(8'h00, 3'd5, 8'd0,   1'b1, 1'b0);
    send_char(8'h80, 3'd6, 8'd129, 1'b0, 1'b1);
    send_char(8'h7F, 3'd7, 8'd255, 1'b1, 1'b1);
    send_char(8'hFF, 3'd7, 8'd66,  1'b0, 1'b1);
    send_char(8'h00, 3'd0, 8'd66,  1'b1, 1'b1);
    send_char(8'h33, 3'd6, 8'd95,  1'b0, 1'b0);
    send_char(8'hCC, 3'd7, 8'd95,  1'b1, 1'b1);
    send_char(8'h12, 3'd0, 8'd33,  1'b0, 1'b1);
    send_char(8'h34, 3'd1, 8'd127, 1'b0, 1'b0);
    send_char(8'hEE, 3'd2, 8'd106, 1'b1, 1'b0);
    send_char(8'h01, 3'd3, 8'd59,  1'b0, 1'b1);
    send_char(8'h10, 3'd4, 8'd44,  1'b1, 1'b1);
    drain();

    addr_set[0] = 8'h00;
    addr_set[1] = 8'hFF;
    addr_set[2] = 8'($urandom_range(255));
    addr_set[3] = RESET_ADDR;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        apb_write(REG_DEVICE_ADDRESS, addr_set[ph - 1]);
        apb_read(REG_DEVICE_ADDRESS, addr_set[ph - 1]);
      end
      idle_on = (ph != 2);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random();
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== oled_glyph_renderer.f =====
+incdir+src
src/ogr_pkg.sv
src/ogr_ctrl.sv
src/ogr_dp.sv
src/oled_glyph_renderer.sv
tb/testbench.sv
